// ----- rtl/core/thok_pkg.sv -----
// Shared types and codes for the one-shot key tracker.
`timescale 1ns / 1ps
`default_nettype none

package thok_pkg;

  // Stream payload widths (tdata padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 3;

  // Field widths
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  typedef logic [2:0] mode_t;
  typedef logic [1:0] func_t;
  typedef logic [2:0] kind_t;
  typedef logic [1:0] status_t;

  // Function codes of an input item
  localparam func_t FUNC_CYCLE  = 2'd0;
  localparam func_t FUNC_KEY    = 2'd1;
  localparam func_t FUNC_REPORT = 2'd2;

  // Per-key modes
  localparam mode_t M_IDLE    = 3'd0;
  localparam mode_t M_PRESSED = 3'd1;
  localparam mode_t M_PREQ    = 3'd2;
  localparam mode_t M_REAL    = 3'd3;
  localparam mode_t M_LATCHED = 3'd4;
  localparam mode_t M_RELEASE = 3'd5;

  // Result kinds
  localparam kind_t KIND_REPLY   = 3'd0;
  localparam kind_t KIND_HELD    = 3'd1;
  localparam kind_t KIND_RELEASE = 3'd2;
  localparam kind_t KIND_FLUSH   = 3'd3;
  localparam kind_t KIND_DONE    = 3'd4;

  // Result status
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_CONSUMED = 2'd1;
  localparam status_t ST_ERROR    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TAP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REAL0  = 8'd3;

  // Reset values
  localparam logic [15:0] TAP_RESET    = 16'd200;
  localparam logic [15:0] ACTIVE_RESET = 16'd1000;

endpackage

`default_nettype wire

// ----- rtl/core/tap_hold_oneshot_key_tracker_unit.sv -----
// Top level of the one-shot key tracker: sequencer over a shared timer/compare unit.
`timescale 1ns / 1ps
`default_nettype none

// One-shot key tracker for NUM_SPECIAL special keys with consecutive codes.
// Input stream (in_*): in_tuser carries the function (cycle start, key event,
// report phase); in_tdata carries now_ms, key_code and switch_bits. Results
// leave on out_*: out_tuser is the result kind, out_tlast marks the final
// result of an item. Registers are written through cfg_* (always ready); the user
// must write them only while the block is idle; the block itself does not enforce it.
// One item is worked on at a time; in_tready is high only in the idle state.
// A single entry walker visits one key entry per cycle (a latched key in the
// listening walk takes a flush and a release step), with one shared 32-bit
// subtract/compare for timer expiry. A cycle start walks the entries only while
// a timer is waiting; a key event sends one reply; a report runs the injection and
// listening walks when due, then the closing result, at most one result a cycle.
// The result register lets the next item be accepted while the final result
// still waits. When out_tready is low, the walker holds on any step that
// has a result to send and resumes once the register drains.
// Synchronous active-low reset returns all keys to idle, clears the flags
// and loads the register reset values; no result is pending after reset.
module tap_hold_oneshot_key_tracker_unit #(
  parameter int unsigned NUM_SPECIAL = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input stream
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // tdata: now_ms[31:0], key_code[47:32], switch_bits[49:48], zero pad
  input  wire logic [thok_pkg::IN_TDATA_W-1:0]       in_tdata,
  // tuser: func[1:0]
  input  wire logic [thok_pkg::IN_TUSER_W-1:0]       in_tuser,
  // Result stream
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // tdata: out_key[15:0], status[17:16], zero pad
  output logic [thok_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // tuser: kind[2:0]
  output logic [thok_pkg::OUT_TUSER_W-1:0]           out_tuser,
  output logic                                       out_tlast,
  // Configuration writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [thok_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [thok_pkg::CFG_DAT_W-1:0]        cfg_data
);

  localparam int unsigned IDX_W = (NUM_SPECIAL > 1) ? $clog2(NUM_SPECIAL) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SPECIAL - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CYC, S_KEY, S_INJ, S_LSN, S_DONE
  } state_t;

  // Registers
  state_t                     state_r, state_nxt;
  logic [IDX_W-1:0]           cnt_r, cnt_nxt;
  logic                       sub_r, sub_nxt;
  thok_pkg::status_t          st_r, st_nxt;
  thok_pkg::mode_t            mode_r [NUM_SPECIAL];
  thok_pkg::mode_t            mode_nxt [NUM_SPECIAL];
  logic [31:0]                press_r [NUM_SPECIAL];
  logic [31:0]                press_nxt [NUM_SPECIAL];
  logic [15:0]                real_r [NUM_SPECIAL];
  logic [15:0]                tap_r, active_r, base_r;
  logic [31:0]                cycle_r, cycle_nxt;
  logic                       listening_r, listening_nxt;
  logic                       waiting_r, waiting_nxt;
  logic                       injecting_r, injecting_nxt;
  logic                       real_down_r, real_down_nxt;
  logic [15:0]                key_r, key_nxt;
  logic [1:0]                 bits_r, bits_nxt;
  logic                       out_valid_r, out_valid_nxt;
  thok_pkg::kind_t            out_kind_r, out_kind_nxt;
  logic [15:0]                out_key_r, out_key_nxt;
  thok_pkg::status_t          out_status_r, out_status_nxt;
  logic                       out_last_r, out_last_nxt;

  // Input field views
  logic                       in_fire;
  thok_pkg::func_t            in_func;
  logic [31:0]                in_now;
  logic [15:0]                in_key;
  logic [1:0]                 in_bits;

  // Shared entry read and timer unit
  logic [15:0]                key_off;
  logic                       is_special;
  logic [IDX_W-1:0]           rd_idx;
  thok_pkg::mode_t            cur_mode;
  logic [31:0]                cur_press;
  logic [15:0]                cur_real;
  logic [31:0]                dt;
  logic [15:0]                limit;
  logic                       in_window;
  logic                       out_free;
  logic                       walk_last;

  // Config decode
  localparam int unsigned CFG_IDX_W_L = thok_pkg::CFG_IDX_W;
  logic [CFG_IDX_W_L-1:0]     rk_sel;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_func   = in_tuser[1:0];
  assign in_now    = in_tdata[31:0];
  assign in_key    = in_tdata[47:32];
  assign in_bits   = in_tdata[49:48];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_key_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  assign cfg_ready  = 1'b1;
  assign rk_sel     = cfg_index - thok_pkg::REG_REAL0;

  // Entry selection: key offset in key-event state, walker count otherwise
  assign key_off    = key_r - base_r;
  assign is_special = (key_off < 16'(NUM_SPECIAL));
  assign rd_idx     = (state_r == S_KEY) ? key_off[IDX_W-1:0] : cnt_r;
  assign cur_mode   = mode_r[rd_idx];
  assign cur_press  = press_r[rd_idx];
  assign cur_real   = real_r[rd_idx];
  assign walk_last  = (cnt_r == LAST_IDX);

  // Shared timer compare: wrapping elapsed time against tap or active limit
  assign dt        = cycle_r - cur_press;
  assign limit     = (cur_mode == thok_pkg::M_LATCHED) ? active_r : tap_r;
  assign in_window = (dt <= {16'd0, limit});

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sub_nxt        = sub_r;
    st_nxt         = st_r;
    mode_nxt       = mode_r;
    press_nxt      = press_r;
    cycle_nxt      = cycle_r;
    listening_nxt  = listening_r;
    waiting_nxt    = waiting_r;
    injecting_nxt  = injecting_r;
    real_down_nxt  = real_down_r;
    key_nxt        = key_r;
    bits_nxt       = bits_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_func)
            thok_pkg::FUNC_CYCLE: begin
              real_down_nxt = 1'b0;
              cycle_nxt     = in_now;
              cnt_nxt       = '0;
              if (waiting_r) begin
                waiting_nxt = 1'b0;
                state_nxt   = S_CYC;
              end
            end
            thok_pkg::FUNC_KEY: begin
              key_nxt   = in_key;
              bits_nxt  = in_bits;
              state_nxt = S_KEY;
            end
            thok_pkg::FUNC_REPORT: begin
              st_nxt  = thok_pkg::ST_OK;
              cnt_nxt = '0;
              sub_nxt = 1'b0;
              if (injecting_r) begin
                injecting_nxt = 1'b0;
                state_nxt     = S_INJ;
              end else if (listening_r && real_down_r) begin
                listening_nxt = 1'b0;
                state_nxt     = S_LSN;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      // Timer expiry walk, one entry per cycle
      S_CYC: begin
        if (cur_mode == thok_pkg::M_PRESSED || cur_mode == thok_pkg::M_PREQ) begin
          if (in_window) waiting_nxt = 1'b1;
          else mode_nxt[rd_idx] = thok_pkg::M_REAL;
        end else if (cur_mode == thok_pkg::M_LATCHED) begin
          if (in_window) waiting_nxt = 1'b1;
          else mode_nxt[rd_idx] = thok_pkg::M_RELEASE;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (walk_last) state_nxt = S_IDLE;
      end

      // Key event: one reply
      S_KEY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = thok_pkg::KIND_REPLY;
          out_key_nxt    = key_r;
          out_status_nxt = thok_pkg::ST_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          if (is_special) begin
            out_status_nxt = thok_pkg::ST_ERROR;
            priority case (1'b1)
              (bits_r == 2'b01): begin
                if (cur_mode == thok_pkg::M_IDLE) begin
                  mode_nxt[rd_idx]  = thok_pkg::M_PRESSED;
                  press_nxt[rd_idx] = cycle_r;
                  listening_nxt     = 1'b1;
                  waiting_nxt       = 1'b1;
                  out_key_nxt       = cur_real;
                  out_status_nxt    = thok_pkg::ST_OK;
                end
              end
              (bits_r == 2'b10): begin
                if (cur_mode == thok_pkg::M_PRESSED) begin
                  mode_nxt[rd_idx] = thok_pkg::M_LATCHED;
                  injecting_nxt    = 1'b1;
                  out_status_nxt   = thok_pkg::ST_CONSUMED;
                end else if (cur_mode == thok_pkg::M_PREQ ||
                             cur_mode == thok_pkg::M_REAL) begin
                  mode_nxt[rd_idx] = thok_pkg::M_IDLE;
                  out_key_nxt      = cur_real;
                  out_status_nxt   = thok_pkg::ST_OK;
                end
              end
              (bits_r == 2'b11): begin
                if (cur_mode == thok_pkg::M_PRESSED || cur_mode == thok_pkg::M_PREQ ||
                    cur_mode == thok_pkg::M_REAL) begin
                  out_key_nxt    = cur_real;
                  out_status_nxt = thok_pkg::ST_OK;
                end
              end
              default: ;
            endcase
          end else if (listening_r && bits_r == 2'b01) begin
            real_down_nxt = 1'b1;
          end
        end
      end

      // Injection walk: held keys and due releases
      S_INJ: begin
        logic adv;
        adv = 1'b1;
        if (cur_mode == thok_pkg::M_LATCHED || cur_mode == thok_pkg::M_RELEASE) begin
          adv = out_free;
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_key_nxt    = cur_real;
            out_status_nxt = thok_pkg::ST_OK;
            out_last_nxt   = 1'b0;
            if (cur_mode == thok_pkg::M_LATCHED) begin
              out_kind_nxt  = thok_pkg::KIND_HELD;
              injecting_nxt = 1'b1;
            end else begin
              out_kind_nxt     = thok_pkg::KIND_RELEASE;
              mode_nxt[rd_idx] = thok_pkg::M_IDLE;
            end
          end
        end
        if (adv) begin
          cnt_nxt = cnt_r + 1'b1;
          if (walk_last) begin
            cnt_nxt = '0;
            if (listening_r && real_down_r) begin
              listening_nxt = 1'b0;
              state_nxt     = S_LSN;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      // Listening walk: another key went down
      S_LSN: begin
        logic adv;
        adv = 1'b1;
        if (cur_mode == thok_pkg::M_PRESSED) begin
          mode_nxt[rd_idx] = thok_pkg::M_PREQ;
        end else if (cur_mode == thok_pkg::M_PREQ) begin
          st_nxt    = thok_pkg::ST_ERROR;
          adv       = 1'b0;
          state_nxt = S_DONE;
        end else if (cur_mode == thok_pkg::M_LATCHED) begin
          adv = 1'b0;
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = thok_pkg::ST_OK;
            out_last_nxt   = 1'b0;
            if (!sub_r) begin
              // flush first, release on the next step
              out_kind_nxt = thok_pkg::KIND_FLUSH;
              out_key_nxt  = '0;
              sub_nxt      = 1'b1;
            end else begin
              out_kind_nxt     = thok_pkg::KIND_RELEASE;
              out_key_nxt      = cur_real;
              mode_nxt[rd_idx] = thok_pkg::M_IDLE;
              sub_nxt          = 1'b0;
              adv              = 1'b1;
            end
          end
        end
        if (adv) begin
          cnt_nxt = cnt_r + 1'b1;
          if (walk_last) state_nxt = S_DONE;
        end
      end

      // Closing result of a report phase
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = thok_pkg::KIND_DONE;
          out_key_nxt    = '0;
          out_status_nxt = st_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, tracking and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sub_r       <= 1'b0;
      st_r        <= thok_pkg::ST_OK;
      cycle_r     <= '0;
      listening_r <= 1'b0;
      waiting_r   <= 1'b0;
      injecting_r <= 1'b0;
      real_down_r <= 1'b0;
      out_valid_r <= 1'b0;
      tap_r       <= thok_pkg::TAP_RESET;
      active_r    <= thok_pkg::ACTIVE_RESET;
      base_r      <= '0;
      for (int i = 0; i < NUM_SPECIAL; i++) begin
        mode_r[i]  <= thok_pkg::M_IDLE;
        press_r[i] <= '0;
        real_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sub_r       <= sub_nxt;
      st_r        <= st_nxt;
      cycle_r     <= cycle_nxt;
      listening_r <= listening_nxt;
      waiting_r   <= waiting_nxt;
      injecting_r <= injecting_nxt;
      real_down_r <= real_down_nxt;
      out_valid_r <= out_valid_nxt;
      mode_r      <= mode_nxt;
      press_r     <= press_nxt;
      // configuration writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == thok_pkg::REG_TAP) tap_r <= cfg_data;
        else if (cfg_index == thok_pkg::REG_ACTIVE) active_r <= cfg_data;
        else if (cfg_index == thok_pkg::REG_BASE) base_r <= cfg_data;
        else if (cfg_index >= thok_pkg::REG_REAL0 && rk_sel < CFG_IDX_W_L'(NUM_SPECIAL))
          real_r[rk_sel[IDX_W-1:0]] <= cfg_data;
      end
    end
    key_r        <= key_nxt;
    bits_r       <= bits_nxt;
    out_kind_r   <= out_kind_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

`default_nettype wire
